// File: rtl/fedl_pkg.sv
`timescale 1ns / 1ps

package fedl_pkg;

   localparam int DELAY_DEPTH = 524288;
   localparam int SAMPLE_BITS = 24;
   localparam int ADDR_BITS   = $clog2(DELAY_DEPTH);
   localparam int DELAY_BITS  = 20;
   localparam int GAIN_BITS   = 16;
   localparam int FRAC_BITS   = 15;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = DELAY_BITS;

   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int MIX_BITS  = PROD_BITS + 1;
   localparam int WIDE_BITS = MIX_BITS - FRAC_BITS;

   localparam logic [GAIN_BITS-1:0] GAIN_ONE   = GAIN_BITS'(32768);
   localparam logic [GAIN_BITS-1:0] WET_RESET  = GAIN_BITS'(16384);
   localparam int                   ROUND_HALF = 1 << (FRAC_BITS - 1);

   localparam logic [CSR_IDX_BITS-1:0] CSR_DELAY    = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_FEEDBACK = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_WET      = CSR_IDX_BITS'(2);

   localparam logic OP_PROCESS = 1'b0;
   localparam logic OP_FLUSH   = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;

   typedef struct packed {
      logic       en;
      addr_type   addr;
      sample_type data;
   } mem_wr_type;

   localparam logic signed [WIDE_BITS-1:0] SAT_HI = WIDE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [WIDE_BITS-1:0] SAT_LO = ~SAT_HI;

   function automatic sample_type sat_sample(input logic signed [WIDE_BITS-1:0] v);
      sample_type r;
      if (v > SAT_HI) begin
         r = SAT_HI[SAMPLE_BITS-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/fedl_store.sv
`timescale 1ns / 1ps

module fedl_store (
   input  logic                 clock,
   input  logic                 rd_en,
   input  fedl_pkg::addr_type   rd_addr,
   input  fedl_pkg::mem_wr_type wr,
   output fedl_pkg::sample_type rd_data
);
   import fedl_pkg::*;

   sample_type mem [DELAY_DEPTH];
   sample_type rd_data_ff;

   // read-first on a same-entry collision; the caller forwards the new value
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/feedback_echo_delay_line_unit.sv
`timescale 1ns / 1ps
// A request passes the p1 and p2 stages and then the response register.
// Throughput: one request per cycle unless the response stalls, including a
// delay of one sample; stage 1 does the forwarded feedback multiply-add.
// Reset clears the write index and the wrap flag; entries not written since
// reset or flush read as zero, so no clearing pass is run.

module feedback_echo_delay_line_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [23:0]                           req_tdata,   // [23:0] sample_in
   input  logic                                  req_tuser,   // [0] operation
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [23:0]                           rsp_tdata,   // [23:0] sample_out
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fedl_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [fedl_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import fedl_pkg::*;

   localparam logic [DELAY_BITS:0] DEPTH_W = (DELAY_BITS + 1)'(DELAY_DEPTH);

   logic [DELAY_BITS-1:0] delay_ff;
   logic [GAIN_BITS-1:0]  fbg_ff;
   logic [GAIN_BITS-1:0]  wet_ff;

   addr_type idx_ff, idx_in;
   logic     full_ff, full_in;

   logic       p1_valid_ff, p1_bypass_ff, p1_hit_ff;
   addr_type   p1_rd_ff, p1_idx_ff;
   sample_type p1_x_ff;

   logic                        p2_valid_ff, p2_bypass_ff;
   addr_type                    p2_idx_ff;
   sample_type                  p2_x_ff, p2_stored_ff;
   logic signed [PROD_BITS-1:0] p2_pd_ff, p2_pw_ff;

   logic       wl_valid_ff;
   addr_type   wl_idx_ff;
   sample_type wl_data_ff;

   logic       rsp_valid_ff;
   sample_type rsp_data_ff;

   logic out_en, p2_en, p1_en, accept, is_flush, bypass_now;
   logic [DELAY_BITS:0] idx_w, dly_w, rd_w;
   addr_type   rd_addr;
   logic       hit_now, rd_en;
   sample_type rd_data, delayed;
   mem_wr_type wr;

   logic [GAIN_BITS-1:0]          fb_gain, wet_gain, dry_gain;
   logic signed [PROD_BITS-1:0]   fb_prod, fb_rnd, pd, pw;
   logic signed [PROD_BITS-FRAC_BITS-1:0] fb_q;
   logic signed [WIDE_BITS-1:0]   stored_sum;
   sample_type                    stored;
   logic signed [MIX_BITS-1:0]    mix_rnd;
   sample_type                    mixed;

   // handshake
   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign p2_en      = !p2_valid_ff || out_en;
   assign p1_en      = !p1_valid_ff || p2_en;
   assign req_tready = p1_en;
   assign accept     = req_tvalid && p1_en;
   assign is_flush   = (req_tuser == OP_FLUSH);
   assign csr_ready  = 1'b1;

   assign bypass_now = (delay_ff == '0) ||
                       ({1'b0, delay_ff} > DEPTH_W);

   // read address and liveness of the entry
   always_comb begin
      idx_w = (DELAY_BITS + 1)'(idx_ff);
      dly_w = {1'b0, delay_ff};
      if (idx_w >= dly_w) begin
         rd_w = idx_w - dly_w;
      end else begin
         rd_w = idx_w + DEPTH_W - dly_w;
      end
      rd_addr = rd_w[ADDR_BITS-1:0];
      hit_now = full_ff || (rd_addr < idx_ff);
      rd_en   = accept && !is_flush && !bypass_now;
   end

   always_comb begin
      idx_in  = idx_ff;
      full_in = full_ff;
      if (accept && is_flush) begin
         idx_in  = '0;
         full_in = 1'b0;
      end else if (rd_en) begin
         if (idx_ff == ADDR_BITS'(DELAY_DEPTH - 1)) begin
            idx_in  = '0;
            full_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   fedl_store u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd_data (rd_data)
   );

   // gains
   always_comb begin
      fb_gain  = (fbg_ff > GAIN_ONE) ? GAIN_ONE : fbg_ff;
      wet_gain = (wet_ff > GAIN_ONE) ? GAIN_ONE : wet_ff;
      dry_gain = GAIN_ONE - wet_gain;
   end

   // stage 1: newest copy of the entry, feedback multiply-add, dry/wet products
   always_comb begin
      priority if (!p1_hit_ff) begin
         delayed = '0;
      end else if (p2_valid_ff && !p2_bypass_ff && (p2_idx_ff == p1_rd_ff)) begin
         delayed = p2_stored_ff;
      end else if (wl_valid_ff && (wl_idx_ff == p1_rd_ff)) begin
         delayed = wl_data_ff;
      end else begin
         delayed = rd_data;
      end
      fb_prod    = delayed * $signed({1'b0, fb_gain});
      fb_rnd     = fb_prod + $signed(PROD_BITS'(ROUND_HALF));
      fb_q       = fb_rnd[PROD_BITS-1:FRAC_BITS];
      stored_sum = WIDE_BITS'(p1_x_ff) + WIDE_BITS'(fb_q);
      stored     = sat_sample(stored_sum);
      pd         = p1_x_ff * $signed({1'b0, dry_gain});
      pw         = delayed * $signed({1'b0, wet_gain});
   end

   // stage 2: mix, write back
   always_comb begin
      mix_rnd = MIX_BITS'(p2_pd_ff) + MIX_BITS'(p2_pw_ff) +
                $signed(MIX_BITS'(ROUND_HALF));
      mixed   = sat_sample(mix_rnd[MIX_BITS-1:FRAC_BITS]);
      wr.en   = p2_valid_ff && !p2_bypass_ff && out_en;
      wr.addr = p2_idx_ff;
      wr.data = p2_stored_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= '0;
         fbg_ff       <= '0;
         wet_ff       <= WET_RESET;
         idx_ff       <= '0;
         full_ff      <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         wl_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_DELAY:    delay_ff <= csr_data[DELAY_BITS-1:0];
               CSR_FEEDBACK: fbg_ff   <= csr_data[GAIN_BITS-1:0];
               CSR_WET:      wet_ff   <= csr_data[GAIN_BITS-1:0];
               default: ;
            endcase
         end
         idx_ff  <= idx_in;
         full_ff <= full_in;
         if (p1_en) begin
            p1_valid_ff <= accept && !is_flush;
         end
         if (p2_en) begin
            p2_valid_ff <= p1_valid_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= p2_valid_ff;
         end
         if (wr.en) begin
            wl_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_bypass_ff <= bypass_now;
         p1_hit_ff    <= hit_now;
         p1_rd_ff     <= rd_addr;
         p1_idx_ff    <= idx_ff;
         p1_x_ff      <= req_tdata;
      end
      if (p2_en) begin
         p2_bypass_ff <= p1_bypass_ff;
         p2_idx_ff    <= p1_idx_ff;
         p2_x_ff      <= p1_x_ff;
         p2_stored_ff <= stored;
         p2_pd_ff     <= pd;
         p2_pw_ff     <= pw;
      end
      if (wr.en) begin
         wl_idx_ff  <= wr.addr;
         wl_data_ff <= wr.data;
      end
      if (out_en) begin
         rsp_data_ff <= p2_bypass_ff ? p2_x_ff : mixed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
